// ===== src/cftf_pkg.sv =====
// ----------------------------------------------------------------------------
// cftf_pkg: shared constants for the covariance-from-factor core
// Sizes of the factor store, index and accumulator widths, output limits.
// ----------------------------------------------------------------------------
package cftf_pkg;

  localparam int MAX_SIZE = 64;
  localparam int IDX_W    = 6;                 // fixed by the row/col fields
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
  localparam int SIZE_W   = 7;
  localparam int VAL_W    = 24;
  localparam int PROD_W   = 2 * VAL_W;
  localparam int COV_W    = 54;
  localparam int ACC_RAW  = PROD_W + $clog2(MAX_SIZE);
  localparam int ACC_W    = (ACC_RAW > COV_W) ? ACC_RAW : COV_W;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(50);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SIZE);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

endpackage

// ===== src/covariance_from_triangular_factor_core.sv =====
// ----------------------------------------------------------------------------
// covariance_from_triangular_factor_core: covariance entries from a factor
// Queries walk the factor column with one multiply-accumulate per cycle,
// set by the two-port read of the factor store; loads give no result.
// Out-of-range queries skip the walk. One item at a time: the next beat
// is taken once the sequencer is back in S_IDLE after a query, later
// while the previous result is still held off.
// Reset (rst, synchronous) clears control state and sets size_in_use to 50;
// the factor store holds no reset value and must be loaded before use.
// ----------------------------------------------------------------------------
module covariance_from_triangular_factor_core (
  input  logic                              clk,
  input  logic                              rst,
  // configuration: size_in_use
  input  logic                              cfg_we,
  input  logic [cftf_pkg::SIZE_W-1:0]       cfg_data,
  // input beat
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              command,
  input  logic [cftf_pkg::IDX_W-1:0]        row_index,
  input  logic [cftf_pkg::IDX_W-1:0]        col_index,
  input  logic signed [cftf_pkg::VAL_W-1:0] factor_value,
  // result beat
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cftf_pkg::COV_W-1:0] covariance_value,
  output logic                              status
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_RUN    = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  localparam logic signed [cftf_pkg::ACC_W-1:0] ACC_HI =
    {{(cftf_pkg::ACC_W - cftf_pkg::COV_W + 1){1'b0}}, {(cftf_pkg::COV_W - 1){1'b1}}};
  localparam logic signed [cftf_pkg::ACC_W-1:0] ACC_LO = ~ACC_HI;

  state_t state;

  logic [cftf_pkg::SIZE_W-1:0] size_in_use;
  logic [cftf_pkg::SIZE_W-1:0] eff_size;
  logic [cftf_pkg::SIZE_W-1:0] last_k;

  // factor store, row-major {row, col}
  logic signed [cftf_pkg::VAL_W-1:0] factor_mem [cftf_pkg::DEPTH];

  logic                             in_beat;
  logic                             out_beat;
  logic                             in_range;

  // query walk: k runs from m up to S-1, reading L[k][m] and L[k][n]
  logic [cftf_pkg::IDX_W-1:0]       k;
  logic [cftf_pkg::IDX_W-1:0]       col_m;
  logic [cftf_pkg::IDX_W-1:0]       col_n;
  logic                             range_err;

  logic                             rd_valid;
  logic signed [cftf_pkg::VAL_W-1:0] rd_a;
  logic signed [cftf_pkg::VAL_W-1:0] rd_b;
  logic                             mul_valid;
  logic signed [cftf_pkg::PROD_W-1:0] prod;
  logic signed [cftf_pkg::ACC_W-1:0] acc;
  logic signed [cftf_pkg::ACC_W-1:0] acc_sat;

  assign eff_size = (size_in_use > cftf_pkg::SIZE_MAX) ? cftf_pkg::SIZE_MAX : size_in_use;
  assign last_k   = eff_size - cftf_pkg::SIZE_W'(1);
  assign in_range = ({1'b0, row_index} < eff_size) && ({1'b0, col_index} < eff_size);

  assign in_stall = (state != S_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  always_comb begin
    if (acc > ACC_HI) begin
      acc_sat = ACC_HI;
    end else if (acc < ACC_LO) begin
      acc_sat = ACC_LO;
    end else begin
      acc_sat = acc;
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= cftf_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      size_in_use <= cfg_data;
    end
  end

  // store: one write port (loads), two registered read ports (query walk)
  always_ff @(posedge clk) begin
    if (in_beat && command == cftf_pkg::CMD_LOAD && in_range) begin
      factor_mem[{row_index, col_index}] <= factor_value;
    end
    rd_a <= factor_mem[{k, col_m}];
    rd_b <= factor_mem[{k, col_n}];
  end

  // multiply stage
  always_ff @(posedge clk) begin
    prod <= rd_a * rd_b;
  end

  // sequencer and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_valid  <= 1'b0;
      mul_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mul_valid <= rd_valid;
      // read issued in S_RUN for the current k
      rd_valid  <= (state == S_RUN);
      // S_FINISH reloads the result register itself
      if (out_beat && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      if (mul_valid) begin
        acc <= acc + cftf_pkg::ACC_W'(prod);
      end else if (state == S_IDLE) begin
        acc <= '0;
      end

      case (state)
        S_IDLE: begin
          if (in_beat && command == cftf_pkg::CMD_QUERY) begin
            if (in_range) begin
              // m = max(r,c), n = min(r,c); walk starts at k = m
              range_err <= 1'b0;
              if (row_index > col_index) begin
                col_m <= row_index;
                col_n <= col_index;
                k     <= row_index;
              end else begin
                col_m <= col_index;
                col_n <= row_index;
                k     <= col_index;
              end
              state <= S_RUN;
            end else begin
              range_err <= 1'b1;
              state     <= S_FINISH;
            end
          end
        end

        S_RUN: begin
          if ({1'b0, k} == last_k) begin
            state <= S_DRAIN;
          end else begin
            k <= k + cftf_pkg::IDX_W'(1);
          end
        end

        S_DRAIN: begin
          if (!rd_valid && !mul_valid) begin
            state <= S_FINISH;
          end
        end

        S_FINISH: begin
          // hold until the result register is free
          if (!out_valid || out_stall == 1'b0) begin
            out_valid <= 1'b1;
            if (range_err) begin
              covariance_value <= '0;
              status           <= cftf_pkg::ST_RANGE;
            end else begin
              covariance_value <= acc_sat[cftf_pkg::COV_W-1:0];
              status           <= cftf_pkg::ST_OK;
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for covariance_from_triangular_factor_core
// Loads factor entries and queries covariance entries over valid/stall beats.
// Expected results come from a local copy of the factor store and size
// setting, and are checked in order, field by field, against each result.
// ----------------------------------------------------------------------------
module tb;
  import cftf_pkg::*;

  // Cycles to let pass after the last result before touching size_in_use:
  // a load gives no result and may still be in flight.
  localparam int IDLE_SLACK = 80;
  localparam int PHASE_OPS  = 180;
  localparam int LONG_HOLD  = 300;
  localparam int QUERY_WIN  = 12;   // random queries stay in the last rows/cols

  localparam logic signed [VAL_W-1:0] FACTOR_MAX = 24'sh7FFFFF;
  localparam logic signed [VAL_W-1:0] FACTOR_MIN = 24'sh800000;

  localparam longint COV_HI = (64'sd1 <<< (COV_W - 1)) - 1;
  localparam longint COV_LO = -(64'sd1 <<< (COV_W - 1));

  typedef struct packed {
    logic signed [COV_W-1:0] cov;
    logic                    st;
  } cov_beat_t;

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     cfg_we       = 1'b0;
  logic [SIZE_W-1:0]        cfg_data     = '0;
  logic                     in_valid     = 1'b0;
  logic                     in_stall;
  logic                     command      = CMD_LOAD;
  logic [IDX_W-1:0]         row_index    = '0;
  logic [IDX_W-1:0]         col_index    = '0;
  logic signed [VAL_W-1:0]  factor_value = '0;
  logic                     out_valid;
  logic                     out_stall    = 1'b0;
  logic signed [COV_W-1:0]  covariance_value;
  logic                     status;

  // Local copy of the block's state. loaded[] marks entries written since
  // reset, so that no query ever reaches an entry the store has not seen.
  logic signed [VAL_W-1:0]  factor_copy [0:DEPTH-1];
  bit                       loaded      [0:DEPTH-1];
  logic [SIZE_W-1:0]        size_setting = SIZE_RESET;
  cov_beat_t                covariance_due [$];

  int send_gap_pct = 0;   // chance of an idle cycle before each input beat
  int recv_gap_pct = 0;   // chance of stalling the output on a cycle
  int hold_left    = 0;   // long output hold-off, counted down below
  int bad_beats    = 0;

  covariance_from_triangular_factor_core dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .row_index        (row_index),
    .col_index        (col_index),
    .factor_value     (factor_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .covariance_value (covariance_value),
    .status           (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Result side stall: random, or held for a long stretch on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_gap_pct);
    end
  end

  // Result checker: every accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    cov_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (covariance_due.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("unexpected result: cov %0d status %0d", covariance_value, status);
      end else begin
        want = covariance_due.pop_front();
        if (covariance_value !== want.cov || status !== want.st) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("mismatch: cov exp %0d got %0d, status exp %0d got %0d",
                     want.cov, covariance_value, want.st, status);
        end
      end
    end
  end

  // S is size_in_use clamped to the store's dimension.
  function automatic int eff_size();
    return (size_setting > SIZE_MAX) ? MAX_SIZE : int'(size_setting);
  endfunction

  // Applies one accepted input beat to the local state; a query queues the
  // covariance entry it must return.
  function automatic void predict_beat(logic cmd, int r, int c,
                                       logic signed [VAL_W-1:0] v);
    int        s;
    int        m;
    int        n;
    longint    acc;
    cov_beat_t e;
    s = eff_size();
    if (cmd == CMD_LOAD) begin
      if (r < s && c < s) begin
        factor_copy[r * MAX_SIZE + c] = v;
        loaded[r * MAX_SIZE + c]      = 1'b1;
      end
      return;
    end
    if (r >= s || c >= s) begin
      e.cov = '0;
      e.st  = ST_RANGE;
    end else begin
      m   = (r > c) ? r : c;
      n   = (r > c) ? c : r;
      acc = 0;
      for (int k = m; k < s; k++)
        acc += longint'(factor_copy[k * MAX_SIZE + m]) *
               longint'(factor_copy[k * MAX_SIZE + n]);
      if (acc > COV_HI) acc = COV_HI;
      if (acc < COV_LO) acc = COV_LO;
      e.cov = COV_W'(acc);
      e.st  = ST_OK;
    end
    covariance_due.push_back(e);
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_factor();
    case ($urandom_range(0, 7))
      0:       return FACTOR_MAX;
      1:       return FACTOR_MIN;
      2:       return '0;
      3:       return '1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // One input beat: optional idle cycles, then hold the payload until taken.
  task automatic send_item(logic cmd, int r, int c, logic signed [VAL_W-1:0] v);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    row_index    <= IDX_W'(r);
    col_index    <= IDX_W'(c);
    factor_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(cmd, r, c, v);
  endtask

  // Query with every factor entry it reads loaded first (random values).
  task automatic query_entry(int r, int c);
    int s;
    int m;
    int n;
    s = eff_size();
    if (r < s && c < s) begin
      m = (r > c) ? r : c;
      n = (r > c) ? c : r;
      for (int k = m; k < s; k++) begin
        if (!loaded[k * MAX_SIZE + m]) send_item(CMD_LOAD, k, m, rand_factor());
        if (!loaded[k * MAX_SIZE + n]) send_item(CMD_LOAD, k, n, rand_factor());
      end
    end
    send_item(CMD_QUERY, r, c, rand_factor());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (covariance_due.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (IDLE_SLACK) @(posedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] v);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    size_setting  = v;
  endtask

  // 4x4 factor with extreme values, a load above the diagonal, one out of
  // range, symmetric queries and out-of-range queries.
  task automatic test_small_matrix();
    write_size(4);
    send_item(CMD_LOAD, 0, 0, FACTOR_MAX);
    send_item(CMD_LOAD, 1, 0, FACTOR_MIN);
    send_item(CMD_LOAD, 1, 1, '1);
    send_item(CMD_LOAD, 2, 0, '0);
    send_item(CMD_LOAD, 2, 1, FACTOR_MAX);
    send_item(CMD_LOAD, 2, 2, FACTOR_MIN);
    send_item(CMD_LOAD, 3, 0, 24'sh123456);
    send_item(CMD_LOAD, 3, 1, -24'sh00ABCD);
    send_item(CMD_LOAD, 3, 2, 24'sh010000);
    send_item(CMD_LOAD, 3, 3, FACTOR_MAX);
    send_item(CMD_LOAD, 0, 3, 24'sh5A5A5A);   // above the diagonal, never read
    send_item(CMD_LOAD, 4, 2, FACTOR_MIN);    // beyond S, dropped
    query_entry(0, 0);
    query_entry(2, 1);
    query_entry(1, 2);
    query_entry(3, 3);
    query_entry(0, 3);
    query_entry(4, 1);
    query_entry(1, 63);
  endtask

  // S = 0: loads dropped, every query out of range.
  task automatic test_size_zero();
    write_size(0);
    send_item(CMD_LOAD, 0, 0, FACTOR_MAX);
    query_entry(0, 0);
  endtask

  // size_in_use above the store dimension clamps to 64; corner indices and
  // the longest walk, all 64 rows of column 0.
  task automatic test_size_clamped();
    write_size(127);
    send_item(CMD_LOAD, 63, 63, FACTOR_MAX);
    send_item(CMD_LOAD, 63, 0, FACTOR_MIN);
    query_entry(63, 63);
    query_entry(0, 63);
    query_entry(0, 0);
  endtask

  // Output held off while queries keep coming, so the core backs up and
  // stalls its input; then the sender waits for a full drain and resumes.
  task automatic test_backpressure();
    write_size(1);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    send_item(CMD_LOAD, 0, 0, rand_factor());
    hold_left = LONG_HOLD;
    for (int i = 0; i < 24; i++) begin
      if ($urandom_range(0, 2) == 0)
        query_entry($urandom_range(1, 63), $urandom_range(0, 63));
      else
        query_entry(0, 0);
    end
    wait_drained();
    for (int i = 0; i < 10; i++) query_entry(0, 0);
  endtask

  // Mostly well-formed queries near the bottom-right corner (entries loaded
  // on demand), in-range loads on or below the diagonal, and some noise:
  // loads over the full index range, queries up to index 63.
  task automatic test_random_mix(int sp, int rp, logic [SIZE_W-1:0] sz);
    int s;
    int lo;
    int r;
    int c;
    int roll;
    int t;
    write_size(sz);
    send_gap_pct = sp;
    recv_gap_pct = rp;
    for (int i = 0; i < PHASE_OPS; i++) begin
      s    = eff_size();
      lo   = (s > QUERY_WIN) ? s - QUERY_WIN : 0;
      roll = $urandom_range(0, 99);
      if (roll < 55 && s > 0) begin
        query_entry($urandom_range(lo, s - 1), $urandom_range(lo, s - 1));
      end else if (roll < 80 && s > 0) begin
        r = $urandom_range(0, s - 1);
        c = $urandom_range(0, s - 1);
        if (c > r) begin
          t = r;
          r = c;
          c = t;
        end
        send_item(CMD_LOAD, r, c, rand_factor());
      end else begin
        if ($urandom_range(0, 1)) begin
          query_entry($urandom_range(lo, 63), $urandom_range(lo, 63));
        end else begin
          r = $urandom_range(0, 63);
          c = $urandom_range(0, 63);
          send_item(CMD_LOAD, r, c, rand_factor());
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_small_matrix();
    test_size_zero();
    test_size_clamped();
    test_backpressure();
    test_random_mix(28, 49, 64);
    test_random_mix(49, 28, SIZE_W'($urandom_range(2, 63)));
    test_random_mix(0, 0, SIZE_W'($urandom_range(65, 127)));
    wait_idle();
    if (bad_beats == 0 && covariance_due.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
